@@ rtl/u8d_pkg.sv @@
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; the front, queue, back and top files of the decoder import it.
package u8d_pkg;

    localparam int unsigned PADDR_W = 3;

    localparam logic [31:0] HEADER_CODE   = 32'h0000_FEFF;
    localparam logic [31:0] MAX_CP_RESET  = 32'h0010_FFFF;

    localparam logic REG_MAX_CODE_POINT = 1'b0;
    localparam logic REG_STRIP_HEADER   = 1'b1;

    typedef enum logic [2:0] {
        ST_CHAR      = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_END_ONLY  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CLS_ASCII = 2'd0,
        CLS_CONT  = 2'd1,
        CLS_LEAD  = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [2:0] len;
        logic [6:0] data;
        logic       eot;
    } tok_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic [31:0] max_code_point;
        logic        strip_header;
    } cfg_t;

endpackage

@@ rtl/u8d_in_if.sv @@
// Byte channel of the UTF-8 stream decoder: valid/ready plus byte and end flag.
// No dependencies.
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_text;

    modport source (output valid, output byte_in, output end_of_text, input ready);
    modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

@@ rtl/u8d_out_if.sv @@
// Result channel of the UTF-8 stream decoder: valid/ready plus code point,
// status and last flag. No dependencies.
interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_point;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, output code_point, output status, output last,
                    input ready);
    modport sink   (input valid, input code_point, input status, input last,
                    output ready);
endinterface

@@ rtl/u8d_front.sv @@
// Front of the decoder: accepts byte beats and classifies each into a token.
// Depends on u8d_pkg and u8d_in_if.
module u8d_front (
    u8d_in_if.sink        byte_ch,
    input  logic          full,
    output logic          push,
    output u8d_pkg::tok_t tok
);
    import u8d_pkg::*;

    logic [7:0] b;

    assign b             = byte_ch.byte_in;
    assign byte_ch.ready = !full;
    assign push          = byte_ch.valid && !full;

    always_comb
    begin
        tok.eot = byte_ch.end_of_text;
        case (b) inside
            [8'h00:8'h7F]:
            begin
                tok.cls  = CLS_ASCII;
                tok.len  = 3'd0;
                tok.data = b[6:0];
            end
            [8'h80:8'hBF]:
            begin
                tok.cls  = CLS_CONT;
                tok.len  = 3'd0;
                tok.data = {1'b0, b[5:0]};
            end
            [8'hC0:8'hDF]:
            begin
                tok.cls  = CLS_LEAD;
                tok.len  = 3'd1;
                tok.data = {2'b0, b[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                tok.cls  = CLS_LEAD;
                tok.len  = 3'd2;
                tok.data = {3'b0, b[3:0]};
            end
            [8'hF0:8'hF7]:
            begin
                tok.cls  = CLS_LEAD;
                tok.len  = 3'd3;
                tok.data = {4'b0, b[2:0]};
            end
            [8'hF8:8'hFB]:
            begin
                tok.cls  = CLS_LEAD;
                tok.len  = 3'd4;
                tok.data = {5'b0, b[1:0]};
            end
            default:
            begin
                tok.cls  = CLS_LEAD;
                tok.len  = 3'd5;
                tok.data = {5'b0, b[1:0]};
            end
        endcase
    end

endmodule

@@ rtl/u8d_fifo.sv @@
// Token queue between the decoder front and back.
// Depends on u8d_pkg.
module u8d_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8d_pkg::tok_t         push_tok,
    input  logic                  pop,
    output u8d_pkg::tok_t         pop_tok,
    output u8d_pkg::fifo_stat_t   stat
);
    import u8d_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    tok_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_tok    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

@@ rtl/u8d_back.sv @@
// Back of the decoder: assembles tokens into code points, checks limits and
// the header, and holds the result register. Depends on u8d_pkg, u8d_out_if.
module u8d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  u8d_pkg::cfg_t       cfg,
    input  u8d_pkg::fifo_stat_t stat,
    input  u8d_pkg::tok_t       tok,
    output logic                pop,
    u8d_out_if.source           char_ch
);
    import u8d_pkg::*;

    logic [31:0] part_reg, part_next;
    logic [2:0]  pend_reg, pend_next;
    logic        first_reg, first_next;
    logic        failed_reg, failed_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_cp_reg, out_cp_next;
    status_t     out_st_reg, out_st_next;
    logic        out_last_reg, out_last_next;

    logic        can_load;
    logic        have;
    logic        done;
    logic [31:0] ch;
    logic [31:0] cont_val;
    logic [31:0] cp;
    status_t     st;

    assign can_load   = !out_valid_reg || char_ch.ready;
    assign pop        = can_load && !stat.empty;
    assign cont_val   = {part_reg[25:0], tok.data[5:0]};

    assign char_ch.valid      = out_valid_reg;
    assign char_ch.code_point = out_cp_reg;
    assign char_ch.status     = out_st_reg;
    assign char_ch.last       = out_last_reg;

    always_comb
    begin
        part_next   = part_reg;
        pend_next   = pend_reg;
        first_next  = first_reg;
        failed_next = failed_reg;
        have        = 1'b0;
        done        = 1'b0;
        ch          = '0;
        cp          = '0;
        st          = ST_CHAR;
        if (pop)
        begin
            if (failed_reg)
            begin
                if (tok.eot)
                begin
                    have = 1'b1;
                    st   = ST_END_ONLY;
                end
            end
            else
            begin
                if (pend_reg == 3'd0)
                begin
                    case (tok.cls)
                        CLS_ASCII:
                        begin
                            ch   = {25'b0, tok.data};
                            done = 1'b1;
                        end
                        CLS_LEAD:
                        begin
                            part_next = {25'b0, tok.data};
                            pend_next = tok.len;
                        end
                        default:
                        begin
                            have = 1'b1;
                            st   = ST_BAD_LEAD;
                        end
                    endcase
                end
                else if (tok.cls != CLS_CONT)
                begin
                    have = 1'b1;
                    st   = ST_BAD_CONT;
                end
                else
                begin
                    part_next = cont_val;
                    pend_next = pend_reg - 3'd1;
                    if (pend_reg == 3'd1)
                    begin
                        ch   = cont_val;
                        done = 1'b1;
                    end
                end

                if (done)
                begin
                    part_next  = '0;
                    first_next = 1'b1;
                    if (first_reg || !cfg.strip_header || ch != HEADER_CODE)
                    begin
                        have = 1'b1;
                        if (ch > cfg.max_code_point)
                        begin
                            st = ST_TOO_LARGE;
                        end
                        else
                        begin
                            cp = ch;
                        end
                    end
                end

                if (have && st != ST_CHAR)
                begin
                    failed_next = 1'b1;
                    part_next   = '0;
                    pend_next   = '0;
                end

                if (tok.eot && !have)
                begin
                    have = 1'b1;
                    st   = (pend_next != 3'd0) ? ST_TRUNCATED : ST_END_ONLY;
                end
            end

            if (tok.eot)
            begin
                part_next   = '0;
                pend_next   = '0;
                first_next  = 1'b0;
                failed_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_cp_next    = out_cp_reg;
        out_st_next    = out_st_reg;
        out_last_next  = out_last_reg;
        if (can_load)
        begin
            out_valid_next = have;
        end
        if (have)
        begin
            out_cp_next   = cp;
            out_st_next   = st;
            out_last_next = tok.eot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg      <= '0;
            pend_reg      <= '0;
            first_reg     <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            part_reg      <= part_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cp_reg   <= out_cp_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder: register port, front, queue, back.
// Depends on u8d_pkg, u8d_in_if, u8d_out_if, u8d_front, u8d_fifo, u8d_back.
//
//   port      dir   beat / access
//   byte_ch   in    byte_in[7:0], end_of_text
//   char_ch   out   code_point[31:0], status[2:0], last
//   apb       in    0x0 max_code_point, 0x4 strip_header
//
// One byte beat per cycle while the queue is not full; a result travels from its byte
// through the queue entry and then the result register.
// The back handles one token per cycle while its result register can take a result.
// Reset clears the queue, the per-text state and the result valid, and sets the configuration registers to defaults.
// A stalled result holds; the queue of FIFO_DEPTH tokens absorbs the stall
// before byte_ch.ready drops.
module utf8_stream_decoder #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    u8d_in_if.sink                       byte_ch,
    u8d_out_if.source                    char_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [u8d_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import u8d_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic       push;
    logic       pop;
    tok_t       front_tok;
    tok_t       queue_tok;
    fifo_stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_STRIP_HEADER) ? {31'b0, cfg_reg.strip_header}
                                                  : cfg_reg.max_code_point;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == REG_MAX_CODE_POINT)
            begin
                cfg_next.max_code_point = pwdata;
            end
            else
            begin
                cfg_next.strip_header = pwdata[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_code_point <= MAX_CP_RESET;
            cfg_reg.strip_header   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    u8d_front u_front (
        .byte_ch (byte_ch),
        .full    (stat.full),
        .push    (push),
        .tok     (front_tok)
    );

    u8d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (front_tok),
        .pop      (pop),
        .pop_tok  (queue_tok),
        .stat     (stat)
    );

    u8d_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .stat    (stat),
        .tok     (queue_tok),
        .pop     (pop),
        .char_ch (char_ch)
    );

    a_cp_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        char_ch.valid && char_ch.status != ST_CHAR |-> char_ch.code_point == '0)
        else $error("code point not zero on a non-character result");

    a_end_carries_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_ch.valid && (char_ch.status == ST_TRUNCATED || char_ch.status == ST_END_ONLY)
        |-> char_ch.last)
        else $error("end result without last");

    a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> !stat.empty)
        else $error("queue empty after a beat was stored");

    a_pop_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("token taken from an empty queue");

endmodule
